// ===== src/shss_pkg.sv =====
// Shared types and constants for the sorted hash set similarity block.
// No dependencies.
package shss_pkg;

	localparam int HASH_W  = 32;
	localparam int CMD_W   = 2;
	localparam int SIM_W   = 7;
	localparam int MATCH_W = 6;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPARE = 2'd2;

	localparam logic [SIM_W-1:0] PERCENT_FULL = 7'd100;
	// 2 * 100: pair factor times full percentage, 8 bits
	localparam logic [7:0]       PAIR_PERCENT = 8'd200;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== src/shss_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module shss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/shss_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Depends on shss_pkg. Requires num < den << QW.
module shss_div #(
	parameter int NW = 14,
	parameter int DW = 7,
	parameter int QW = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [NW-1:0]          num,
	input  logic [DW-1:0]          den,
	output logic [QW-1:0]          quot,
	output shss_pkg::div_status_t  status
);
	import shss_pkg::*;

	localparam int SW = (QW > 1) ? $clog2(QW) : 1;

	logic          busy_q;
	logic          done_q;
	logic [SW-1:0] cnt_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] dsh_q;
	logic [QW-1:0] quot_q;
	logic          fits;

	assign fits = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SW'(QW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= NW'(den) << (QW - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[QW-2:0], fits};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign quot        = quot_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

// ===== src/sorted_hash_set_similarity.sv =====
// Top level of the sorted hash set similarity block: command decode, list
// storage, merge sequencer and output register. Depends on shss_pkg,
// shss_ram and shss_div.
//
// Two lists of 32-bit hashes, A and B, are filled one word per transfer
// (cmd load A / load B); each list should be in ascending order and holds
// up to MAX_ENTRIES words, further loads are dropped. A load produces no
// result. A compare transfer walks both lists in a merge, one step per
// cycle through a 32-bit less-than and equality compare of the two heads
// read from both list RAMs, stopping when either list runs out; it then
// runs a serial divide of 200*matches by (count_a + count_b), one
// quotient bit per cycle for a 7-bit quotient, and presents similarity
// (clamped to 100) and match_count (low 6 bits) as one result, after
// which both lists are empty. The merge runs at most
// count_a + count_b - 1 steps; when one or both lists are empty a compare
// skips the merge and divide. in_ready is low for the whole compare.
// Loads may continue while a result waits on the output; a new compare
// completes only once the previous result has been taken. Unused command
// code 3 is ignored.
module sorted_hash_set_similarity #(
	parameter int MAX_ENTRIES = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [shss_pkg::CMD_W-1:0]    cmd,
	input  logic [shss_pkg::HASH_W-1:0]   hash_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [shss_pkg::SIM_W-1:0]    similarity,
	output logic [shss_pkg::MATCH_W-1:0]  match_count
);
	import shss_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);   // holds a count up to the depth
	localparam int TW = CW + 1;                    // count_a + count_b
	localparam int NW = CW + 8;                    // hits * 200

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MERGE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [CW-1:0]    ca_q, cb_q;
	logic [CW-1:0]    i_q, j_q;
	logic [CW-1:0]    hits_q;
	logic [SIM_W-1:0] sim_res_q;

	logic             out_valid_q;
	logic [SIM_W-1:0] similarity_q;
	logic [CW-1:0]    match_q;

	logic              in_xfer;
	logic              we_a, we_b;
	logic [HASH_W-1:0] rd_a, rd_b;
	logic [AW-1:0]     raddr_a, raddr_b;

	logic          both_live;
	logic          a_lt, eq;
	logic [CW-1:0] i_nxt, j_nxt;

	logic              div_start;
	logic [NW-1:0]     div_num;
	logic [TW-1:0]     total;
	logic [SIM_W-1:0]  div_quot;
	div_status_t       div_st;

	logic [CW+MATCH_W-1:0] match_ext;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;

	// appends to a full list are dropped
	assign we_a = in_xfer && (cmd == CMD_LOAD_A) && (ca_q < CW'(MAX_ENTRIES));
	assign we_b = in_xfer && (cmd == CMD_LOAD_B) && (cb_q < CW'(MAX_ENTRIES));

	// merge step: one compare of the two list heads per cycle
	assign both_live = (i_q < ca_q) && (j_q < cb_q);
	assign a_lt      = rd_a < rd_b;
	assign eq        = rd_a == rd_b;
	assign i_nxt     = i_q + CW'(a_lt || eq);
	assign j_nxt     = j_q + CW'(!a_lt);

	// read address runs one step ahead so the RAM output is the current head;
	// outside the merge it parks on entry 0, ready for the first step
	assign raddr_a = (state_q == ST_MERGE && both_live) ? i_nxt[AW-1:0] : '0;
	assign raddr_b = (state_q == ST_MERGE && both_live) ? j_nxt[AW-1:0] : '0;

	shss_ram #(
		.WIDTH (HASH_W),
		.DEPTH (MAX_ENTRIES),
		.AW    (AW)
	) u_list_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (ca_q[AW-1:0]),
		.wdata (hash_value),
		.raddr (raddr_a),
		.rdata (rd_a)
	);

	shss_ram #(
		.WIDTH (HASH_W),
		.DEPTH (MAX_ENTRIES),
		.AW    (AW)
	) u_list_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (cb_q[AW-1:0]),
		.wdata (hash_value),
		.raddr (raddr_b),
		.rdata (rd_b)
	);

	// divide 200*hits by the combined length once the merge is over
	assign div_start = (state_q == ST_MERGE) && !both_live;
	assign div_num   = NW'(hits_q) * NW'(PAIR_PERCENT);
	assign total     = TW'(ca_q) + TW'(cb_q);

	shss_div #(
		.NW (NW),
		.DW (TW),
		.QW (SIM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (total),
		.quot   (div_quot),
		.status (div_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ca_q         <= '0;
			cb_q         <= '0;
			i_q          <= '0;
			j_q          <= '0;
			hits_q       <= '0;
			sim_res_q    <= '0;
			out_valid_q  <= 1'b0;
			similarity_q <= '0;
			match_q      <= '0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (we_a) begin
						ca_q <= ca_q + 1'b1;
					end
					if (we_b) begin
						cb_q <= cb_q + 1'b1;
					end
					if (in_xfer && cmd == CMD_COMPARE) begin
						i_q    <= '0;
						j_q    <= '0;
						hits_q <= '0;
						if (ca_q == '0 && cb_q == '0) begin
							sim_res_q <= PERCENT_FULL;
							state_q   <= ST_DONE;
						end else if (ca_q == '0 || cb_q == '0) begin
							sim_res_q <= '0;
							state_q   <= ST_DONE;
						end else begin
							state_q <= ST_MERGE;
						end
					end
				end
				ST_MERGE: begin
					if (both_live) begin
						i_q <= i_nxt;
						j_q <= j_nxt;
						if (eq) begin
							hits_q <= hits_q + 1'b1;
						end
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_st.done) begin
						sim_res_q <= (div_quot > PERCENT_FULL) ? PERCENT_FULL : div_quot;
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						similarity_q <= sim_res_q;
						match_q      <= hits_q;
						ca_q         <= '0;
						cb_q         <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign match_ext   = {{MATCH_W{1'b0}}, match_q};
	assign out_valid   = out_valid_q;
	assign similarity  = similarity_q;
	assign match_count = match_ext[MATCH_W-1:0];

`ifndef ASSERT_OFF
	a_sim_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> similarity <= PERCENT_FULL)
		else $error("similarity above 100");

	a_merge_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MERGE |-> (i_q <= ca_q) && (j_q <= cb_q) && (hits_q <= i_q))
		else $error("merge index beyond list count");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(ca_q <= CW'(MAX_ENTRIES)) && (cb_q <= CW'(MAX_ENTRIES)))
		else $error("list count above capacity");

	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		(div_st.busy || div_st.done) |-> state_q == ST_DIV)
		else $error("divider active outside divide phase");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (!out_valid_q || out_ready)) |=>
			(ca_q == '0) && (cb_q == '0) && out_valid_q)
		else $error("compare did not clear lists or post result");
`endif

endmodule
